// ===== rtl/core/omd_pkg.sv =====
package omd_pkg;

   localparam int MaxPacketDefault = 2048;

   // Parse phases
   localparam logic [2:0] PH_ADDR     = 3'd0;
   localparam logic [2:0] PH_ADDR_PAD = 3'd1;
   localparam logic [2:0] PH_TAGS     = 3'd2;
   localparam logic [2:0] PH_TAGS_PAD = 3'd3;
   localparam logic [2:0] PH_ARGS     = 3'd4;
   localparam logic [2:0] PH_STRARG   = 3'd5;
   localparam logic [2:0] PH_DONE     = 3'd6;

   // Type-tag classes
   localparam logic [2:0] TC_EMPTY = 3'd0;
   localparam logic [2:0] TC_COMMA = 3'd1;
   localparam logic [2:0] TC_I     = 3'd2;
   localparam logic [2:0] TC_IF    = 3'd3;
   localparam logic [2:0] TC_F     = 3'd4;
   localparam logic [2:0] TC_S     = 3'd5;
   localparam logic [2:0] TC_OTHER = 3'd6;

   // Result kinds
   localparam logic [2:0] K_PATH   = 3'd0;
   localparam logic [2:0] K_STR    = 3'd1;
   localparam logic [2:0] K_ON     = 3'd2;
   localparam logic [2:0] K_OFF    = 3'd3;
   localparam logic [2:0] K_FPARAM = 3'd4;
   localparam logic [2:0] K_IPARAM = 3'd5;
   localparam logic [2:0] K_SPARAM = 3'd6;
   localparam logic [2:0] K_DROP   = 3'd7;

   localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  char_code;
      logic [31:0] integer_value;
      logic [31:0] float_bits;
   } result_type;

   // Address literals, indexed by byte position
   function automatic logic [7:0] lit_on(input logic [2:0] p);
      unique case (p)
         3'd0: lit_on = "/";
         3'd1: lit_on = "n";
         3'd2: lit_on = "o";
         3'd3: lit_on = "t";
         3'd4: lit_on = "e";
         3'd5: lit_on = "O";
         3'd6: lit_on = "n";
         default: lit_on = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] lit_off(input logic [2:0] p);
      unique case (p)
         3'd0: lit_off = "/";
         3'd1: lit_off = "n";
         3'd2: lit_off = "o";
         3'd3: lit_off = "t";
         3'd4: lit_off = "e";
         3'd5: lit_off = "O";
         3'd6: lit_off = "f";
         default: lit_off = "f";
      endcase
   endfunction

   function automatic logic [7:0] lit_param(input logic [2:0] p);
      unique case (p)
         3'd0: lit_param = "/";
         3'd1: lit_param = "p";
         3'd2: lit_param = "a";
         3'd3: lit_param = "r";
         3'd4: lit_param = "a";
         3'd5: lit_param = "m";
         3'd6: lit_param = "/";
         default: lit_param = 8'h00;
      endcase
   endfunction

   function automatic logic [2:0] next_tag(input logic [2:0] cls, input logic [7:0] c);
      priority case (cls)
         TC_EMPTY: next_tag = (c == ",") ? TC_COMMA : TC_OTHER;
         TC_COMMA: begin
            if (c == "i")      next_tag = TC_I;
            else if (c == "f") next_tag = TC_F;
            else if (c == "s") next_tag = TC_S;
            else               next_tag = TC_OTHER;
         end
         TC_I:    next_tag = (c == "f") ? TC_IF : TC_OTHER;
         default: next_tag = TC_OTHER;
      endcase
   endfunction

endpackage

// ===== rtl/core/omd_parser.sv =====
module omd_parser import omd_pkg::*; #(
   parameter int MAX_PACKET = MaxPacketDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_in,
   input  logic       last,
   output logic       emit,
   output result_type result
);
   localparam int PosW = $clog2(MAX_PACKET + 1);

   logic [2:0]      phase_ff, phase_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [2:0]      am_ff, am_in;
   logic            nonempty_ff, nonempty_in;
   logic [2:0]      tag_ff, tag_in;
   logic [63:0]     shift_ff, shift_in;
   logic [3:0]      nbytes_ff, nbytes_in;
   logic            term_ff, term_in;

   logic            live, aligned_next, ch_emit, small7, small8, prm_ok, have4;
   logic [2:0]      ch_kind, after_tags, am_cur;
   logic [7:0]      ch;
   logic [31:0]     first4;
   logic [2:0]      p3;

   assign live = (pos_ff < PosW'(MAX_PACKET));
   assign aligned_next = (pos_ff[1:0] == 2'd3);
   assign small7 = (pos_ff < PosW'(7));
   assign small8 = (pos_ff < PosW'(8));
   assign p3 = pos_ff[2:0];
   assign after_tags = (am_ff[2] && nonempty_ff && tag_ff == TC_S) ? PH_STRARG : PH_ARGS;

   // Next-state logic for one packet byte
   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; am_in = am_ff;
      nonempty_in = nonempty_ff; tag_in = tag_ff; shift_in = shift_ff;
      nbytes_in = nbytes_ff; term_in = term_ff;
      ch_emit = 1'b0; ch_kind = K_PATH; ch = byte_in;
      am_cur = am_ff;
      if (live) begin
         pos_in = pos_ff + PosW'(1);
         unique case (phase_ff)
            PH_ADDR: begin
               if (byte_in == 8'h00) begin
                  if (pos_ff != PosW'(7)) am_cur[0] = 1'b0;
                  if (pos_ff != PosW'(8)) am_cur[1] = 1'b0;
                  if (small7) am_cur[2] = 1'b0;
                  phase_in = aligned_next ? PH_TAGS : PH_ADDR_PAD;
               end else begin
                  if (small7) begin
                     if (byte_in != lit_on(p3)) am_cur[0] = 1'b0;
                     if (byte_in != lit_param(p3)) am_cur[2] = 1'b0;
                  end else begin
                     am_cur[0] = 1'b0;
                  end
                  if (!small8 || byte_in != lit_off(p3)) am_cur[1] = 1'b0;
                  if (!small7 && am_cur[2]) begin
                     nonempty_in = 1'b1;
                     ch_emit = 1'b1;
                     ch = (byte_in == "/") ? "." : byte_in;
                  end
               end
               am_in = am_cur;
            end
            PH_ADDR_PAD: if (aligned_next) phase_in = PH_TAGS;
            PH_TAGS: begin
               if (byte_in == 8'h00) phase_in = aligned_next ? after_tags : PH_TAGS_PAD;
               else tag_in = next_tag(tag_ff, byte_in);
            end
            PH_TAGS_PAD: if (aligned_next) phase_in = after_tags;
            PH_ARGS: begin
               if (!nbytes_ff[3]) begin
                  shift_in = {shift_ff[55:0], byte_in};
                  nbytes_in = nbytes_ff + 4'd1;
               end
            end
            PH_STRARG: begin
               if (byte_in == 8'h00) begin
                  term_in = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  ch_emit = 1'b1;
                  ch_kind = K_STR;
               end
            end
            default: ;
         endcase
      end
   end

   // Final decision on the packet's last byte, from the updated state
   assign have4 = (nbytes_in >= 4'd4);
   assign prm_ok = am_in[2] && nonempty_in;
   always_comb begin
      unique case (nbytes_in)
         4'd4:    first4 = shift_in[31:0];
         4'd5:    first4 = shift_in[39:8];
         4'd6:    first4 = shift_in[47:16];
         4'd7:    first4 = shift_in[55:24];
         4'd8:    first4 = shift_in[63:32];
         default: first4 = 32'd0;
      endcase
   end

   always_comb begin
      result = '{kind: K_DROP, char_code: 8'd0, integer_value: 32'd0, float_bits: 32'd0};
      emit = 1'b1;
      if (last) begin
         if (am_in[0] && tag_in == TC_I && have4) begin
            result.kind = K_ON; result.integer_value = first4;
            result.float_bits = FLOAT_ONE;
         end else if (am_in[0] && tag_in == TC_IF && nbytes_in[3]) begin
            result.kind = K_ON; result.integer_value = shift_in[63:32];
            result.float_bits = shift_in[31:0];
         end else if (am_in[1] && tag_in == TC_I && have4) begin
            result.kind = K_OFF; result.integer_value = first4;
         end else if (prm_ok && tag_in == TC_F && have4) begin
            result.kind = K_FPARAM; result.float_bits = first4;
         end else if (prm_ok && tag_in == TC_I && have4) begin
            result.kind = K_IPARAM; result.integer_value = first4;
         end else if (prm_ok && tag_in == TC_S && term_in) begin
            result.kind = K_SPARAM;
         end
      end else begin
         emit = ch_emit;
         result.kind = ch_kind;
         result.char_code = ch;
      end
   end

   // Parser state; the packet's last byte returns it to reset
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff <= PH_ADDR; pos_ff <= '0; am_ff <= 3'b111; nonempty_ff <= 1'b0;
         tag_ff <= TC_EMPTY; shift_ff <= '0; nbytes_ff <= '0; term_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; pos_ff <= pos_in; am_ff <= am_in;
         nonempty_ff <= nonempty_in; tag_ff <= tag_in; shift_ff <= shift_in;
         nbytes_ff <= nbytes_in; term_ff <= term_in;
      end
   end
endmodule

// ===== rtl/core/osc_message_decoder.sv =====
// OSC message decoder.
// The request channel carries one packet byte per transaction, with
// req_packet_end set on the final byte of a UDP packet. The response
// channel carries path characters, string characters and exactly one
// event or drop per packet, on the transaction made by its final byte.
// Each accepted byte is registered in the input register, decoded by
// the combinational parser step, and its result (if any) is written to
// the response register, which presents it until the receiver takes it.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the response register holds its transaction
// and the input register keeps one byte waiting; req_stall rises only
// when both are full. Bytes at or past MAX_PACKET are ignored except
// that their end flag still closes the packet.
// Reset is synchronous and clears the parser and both register stages;
// the block takes bytes in the first cycle after reset.
module osc_message_decoder import omd_pkg::*; #(
   parameter int MAX_PACKET = MaxPacketDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_packet_byte,
   input  logic               req_packet_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_char_code,
   output logic signed [31:0] rsp_integer_value,
   output logic [31:0]        rsp_float_bits
);
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       step, emit, out_free;
   result_type res;

   // The parser advances whenever the response register can take its result
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   omd_parser #(.MAX_PACKET(MAX_PACKET)) u_parser (
      .clock(clock), .reset(reset), .step(step), .byte_in(in_byte_ff),
      .last(in_last_ff), .emit(emit), .result(res)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_packet_byte;
         in_last_ff <= req_packet_end;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && emit;
      end
   end
   always_ff @(posedge clock) begin
      if (out_free && step && emit) begin
         out_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_char_code     = out_ff.char_code;
   assign rsp_integer_value = out_ff.integer_value;
   assign rsp_float_bits    = out_ff.float_bits;
endmodule
